// ----- sv/spf_pkg.sv -----
// Shared types and constants for the servo pose packet framer.
// No dependencies; used by every module of the block.
`default_nettype none

package spf_pkg;

   typedef struct packed {
      logic signed [15:0] yaw_target;
      logic signed [15:0] pitch_target;
      logic signed [15:0] speed_request;
   } req_type;

   typedef struct packed {
      logic [7:0] wire_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic [9:0] yaw_raw;
      logic [9:0] pitch_goal;
      logic [9:0] speed;
   } cmd_type;

   localparam int unsigned PKT_LEN = 13;

   localparam logic [7:0] HDR_BYTE   = 8'hFF;
   localparam logic [7:0] LEN_BYTE   = 8'h09;
   localparam logic [7:0] OP_WRITE   = 8'h03;
   localparam logic [7:0] ADDR_GOAL  = 8'h2A;
   localparam logic [7:0] ID_YAW     = 8'h01;
   localparam logic [7:0] ID_PITCH   = 8'h02;

   // Byte positions inside one packet.
   localparam logic [3:0] BP_HDR0  = 4'd0;
   localparam logic [3:0] BP_HDR1  = 4'd1;
   localparam logic [3:0] BP_ID    = 4'd2;
   localparam logic [3:0] BP_LEN   = 4'd3;
   localparam logic [3:0] BP_INST  = 4'd4;
   localparam logic [3:0] BP_ADDR  = 4'd5;
   localparam logic [3:0] BP_POSH  = 4'd6;
   localparam logic [3:0] BP_POSL  = 4'd7;
   localparam logic [3:0] BP_TIMH  = 4'd8;
   localparam logic [3:0] BP_TIML  = 4'd9;
   localparam logic [3:0] BP_SPDH  = 4'd10;
   localparam logic [3:0] BP_SPDL  = 4'd11;
   localparam logic [3:0] BP_CSUM  = 4'd12;

   // x*16/50 == x*8/25; divide by 25 as multiply by ceil(2^24/25), exact below 2^24/9.
   localparam logic [19:0] RECIP_25    = 20'd671089;
   localparam int unsigned RECIP_SHIFT = 24;

   localparam logic signed [17:0] POS_CENTER = 18'sd512;
   localparam logic signed [17:0] POS_MIN    = 18'sd200;
   localparam logic signed [17:0] POS_MAX    = 18'sd824;
   localparam logic signed [16:0] PITCH_MID  = 17'sd425;
   localparam logic [9:0]         SPEED_MAX  = 10'd1023;

   localparam logic [2:0] REG_BUS_READY = 3'd0;

   function automatic logic [9:0] sat_pos(input logic signed [17:0] v);
      logic [9:0] r;
      if (v < POS_MIN) begin
         r = POS_MIN[9:0];
      end else if (v > POS_MAX) begin
         r = POS_MAX[9:0];
      end else begin
         r = v[9:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/servo_pose_packet_framer_top.sv -----
// Flow: an accepted command passes the front end and the queue; its 26 bytes then strobe back to back.
// Ordering: the byte serializer sends one command at a time; QUEUE_DEPTH commands
// may be taken ahead. Commands taken while bus_ready is low produce no bytes.
// Reset: synchronous; clears bus_ready, the queue and the serializer. Receiver cannot stall.
// Holds the register port and wires front end, queue and serializer.
// Depends on spf_pkg, spf_front, spf_queue, spf_back.
`default_nettype none

module servo_pose_packet_framer_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire spf_pkg::req_type req_cmd,
   output logic                  rsp_strobe,
   output spf_pkg::rsp_type      rsp_beat,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

   logic bus_ready_ff, bus_ready_in;
   logic accept, csr_wr;

   logic             cmd_valid;
   spf_pkg::cmd_type cmd, head;
   logic [1:0]       inflight;
   logic [CW-1:0]    count;
   logic [CW:0]      occupied;
   logic             pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      bus_ready_in = bus_ready_ff;
      if (csr_wr && csr_paddr == spf_pkg::REG_BUS_READY) begin
         bus_ready_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ready_ff <= 1'b0;
      end else begin
         bus_ready_ff <= bus_ready_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == spf_pkg::REG_BUS_READY[2]) ? {31'b0, bus_ready_ff}
                                                                  : 32'b0;

   assign occupied = (CW+1)'(count) + (CW+1)'(inflight);
   assign busy     = (occupied >= (CW+1)'(QUEUE_DEPTH));
   assign accept   = start & ~busy;

   spf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .bus_ready (bus_ready_ff),
      .req       (req_cmd),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .inflight  (inflight)
   );

   spf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_valid),
      .push_data (cmd),
      .pop       (pop),
      .head      (head),
      .count     (count)
   );

   spf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (count != '0),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_beat   (rsp_beat)
   );

endmodule

`default_nettype wire

// ----- sv/spf_front.sv -----
// Front end: takes pose commands, maps targets to raw positions and saturates speed.
// Depends on spf_pkg.
`default_nettype none

module spf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             bus_ready,
   input  wire spf_pkg::req_type req,
   output logic                  cmd_valid,
   output spf_pkg::cmd_type      cmd,
   output logic [1:0]            inflight
);

   logic             a_valid_ff, a_valid_in;
   spf_pkg::req_type a_req_ff;

   logic        b_valid_ff, b_valid_in;
   logic [39:0] yaw_prod_ff, pitch_prod_ff;
   logic        yaw_neg_ff, pitch_neg_ff;
   logic [9:0]  speed_ff, speed_in;

   logic signed [16:0] yaw_ext, pitch_diff;
   logic [16:0]        yaw_mag, pitch_mag;
   logic [39:0]        yaw_prod_in, pitch_prod_in;

   logic signed [17:0] yaw_q, pitch_q, yaw_sum, pitch_sum;

   // Stage A: magnitudes and reciprocal multiply.
   assign yaw_ext    = {a_req_ff.yaw_target[15], a_req_ff.yaw_target};
   assign pitch_diff = {a_req_ff.pitch_target[15], a_req_ff.pitch_target} - spf_pkg::PITCH_MID;
   assign yaw_mag    = yaw_ext[16] ? 17'(-yaw_ext) : 17'(yaw_ext);
   assign pitch_mag  = pitch_diff[16] ? 17'(-pitch_diff) : 17'(pitch_diff);

   assign yaw_prod_in   = {yaw_mag, 3'b000} * spf_pkg::RECIP_25;
   assign pitch_prod_in = {pitch_mag, 3'b000} * spf_pkg::RECIP_25;

   always_comb begin
      if (a_req_ff.speed_request[15]) begin
         speed_in = '0;
      end else if (|a_req_ff.speed_request[14:10]) begin
         speed_in = spf_pkg::SPEED_MAX;
      end else begin
         speed_in = a_req_ff.speed_request[9:0];
      end
   end

   assign a_valid_in = accept & bus_ready;
   assign b_valid_in = a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_req_ff <= req;
      end
      yaw_prod_ff   <= yaw_prod_in;
      pitch_prod_ff <= pitch_prod_in;
      yaw_neg_ff    <= yaw_ext[16];
      pitch_neg_ff  <= pitch_diff[16];
      speed_ff      <= speed_in;
   end

   // Stage B: apply sign about center and clamp.
   assign yaw_q   = $signed({2'b00, yaw_prod_ff[39:spf_pkg::RECIP_SHIFT]});
   assign pitch_q = $signed({2'b00, pitch_prod_ff[39:spf_pkg::RECIP_SHIFT]});

   assign yaw_sum   = yaw_neg_ff ? (spf_pkg::POS_CENTER - yaw_q)
                                 : (spf_pkg::POS_CENTER + yaw_q);
   assign pitch_sum = pitch_neg_ff ? (spf_pkg::POS_CENTER + pitch_q)
                                   : (spf_pkg::POS_CENTER - pitch_q);

   assign cmd_valid      = b_valid_ff;
   assign cmd.yaw_raw    = spf_pkg::sat_pos(yaw_sum);
   assign cmd.pitch_goal = spf_pkg::sat_pos(pitch_sum);
   assign cmd.speed      = speed_ff;

   assign inflight = {1'b0, a_valid_ff} + {1'b0, b_valid_ff};

endmodule

`default_nettype wire

// ----- sv/spf_queue.sv -----
// Command queue between the front end and the byte serializer.
// Depends on spf_pkg.
`default_nettype none

module spf_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire spf_pkg::cmd_type           push_data,
   input  wire logic                       pop,
   output spf_pkg::cmd_type                head,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH+1);

   spf_pkg::cmd_type mem [DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem[rd_ptr_ff];
   assign count = count_ff;

endmodule

`default_nettype wire

// ----- sv/spf_back.sv -----
// Byte serializer: frames two servo write packets per queued command, one byte a cycle while the queue is not empty.
// Depends on spf_pkg.
`default_nettype none

module spf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire spf_pkg::cmd_type head,
   output logic                  pop,
   output logic                  rsp_strobe,
   output spf_pkg::rsp_type      rsp_beat
);

   logic       pkt_ff, pkt_in;
   logic [3:0] pos_ff, pos_in;

   logic             strobe_ff;
   spf_pkg::rsp_type beat_ff, beat_in;

   logic [7:0] id_byte, pos_h, pos_l, spd_h, spd_l, csum;
   logic [9:0] pos_raw;
   logic       pkt_end;

   assign id_byte = pkt_ff ? spf_pkg::ID_PITCH : spf_pkg::ID_YAW;
   assign pos_raw = pkt_ff ? head.pitch_goal : head.yaw_raw;
   assign pos_h   = {6'b0, pos_raw[9:8]};
   assign pos_l   = pos_raw[7:0];
   assign spd_h   = {6'b0, head.speed[9:8]};
   assign spd_l   = head.speed[7:0];
   assign csum    = ~(id_byte + spf_pkg::LEN_BYTE + spf_pkg::OP_WRITE + spf_pkg::ADDR_GOAL
                      + pos_h + pos_l + spd_h + spd_l);

   assign pkt_end = (pos_ff == spf_pkg::BP_CSUM);

   always_comb begin
      beat_in.last_byte = pkt_ff & pkt_end;
      unique case (pos_ff)
         spf_pkg::BP_HDR0: beat_in.wire_byte = spf_pkg::HDR_BYTE;
         spf_pkg::BP_HDR1: beat_in.wire_byte = spf_pkg::HDR_BYTE;
         spf_pkg::BP_ID:   beat_in.wire_byte = id_byte;
         spf_pkg::BP_LEN:  beat_in.wire_byte = spf_pkg::LEN_BYTE;
         spf_pkg::BP_INST: beat_in.wire_byte = spf_pkg::OP_WRITE;
         spf_pkg::BP_ADDR: beat_in.wire_byte = spf_pkg::ADDR_GOAL;
         spf_pkg::BP_POSH: beat_in.wire_byte = pos_h;
         spf_pkg::BP_POSL: beat_in.wire_byte = pos_l;
         spf_pkg::BP_TIMH: beat_in.wire_byte = 8'h00;
         spf_pkg::BP_TIML: beat_in.wire_byte = 8'h00;
         spf_pkg::BP_SPDH: beat_in.wire_byte = spd_h;
         spf_pkg::BP_SPDL: beat_in.wire_byte = spd_l;
         spf_pkg::BP_CSUM: beat_in.wire_byte = csum;
         default:          beat_in.wire_byte = 8'h00;
      endcase
   end

   assign pop = head_valid & pkt_ff & pkt_end;

   always_comb begin
      pkt_in = pkt_ff;
      pos_in = pos_ff;
      if (head_valid) begin
         if (pkt_end) begin
            pos_in = '0;
            pkt_in = ~pkt_ff;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff    <= 1'b0;
         pos_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         pkt_ff    <= pkt_in;
         pos_ff    <= pos_in;
         strobe_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_beat   = beat_ff;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for servo_pose_packet_framer_top: drives pose commands, predicts the two servo
// write packets per command and checks every byte beat on the result port.
// Depends on spf_pkg and the framer RTL.
module tb_top;

   localparam int         DRAIN_CYCLES   = 120;
   localparam int         QUIET_LIMIT    = 4000;
   localparam logic [2:0] ADDR_BUS_READY = 3'(4 * spf_pkg::REG_BUS_READY);
   localparam logic [2:0] ADDR_UNUSED    = 3'd4;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   spf_pkg::req_type req_cmd = '0;
   logic             rsp_strobe;
   spf_pkg::rsp_type rsp_beat;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [2:0]       csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   spf_pkg::req_type pending_cmds[$];
   spf_pkg::rsp_type expected_bytes[$];
   bit      bus_ready_copy = 1'b0;
   int      send_idle_pct = 0;
   int      errors = 0;
   int      quiet_cycles = 0;

   servo_pose_packet_framer_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_cmd     (req_cmd),
      .rsp_strobe  (rsp_strobe),
      .rsp_beat    (rsp_beat),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      if (errors < 40) begin
         $display("MISMATCH @%0t: %s", $realtime, msg);
      end
      errors++;
   endtask

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // Predict the two write packets of one pose command; none while the bus is not ready.
   function automatic void frame_pose(spf_pkg::req_type cmd);
      int          yaw_pos;
      int          pitch_pos;
      int          spd;
      logic [15:0] pos_w;
      logic [15:0] spd_w;
      logic [7:0]  body [10];
      logic [7:0]  sum;
      if (!bus_ready_copy) return;
      yaw_pos   = clamp(512 + (int'($signed(cmd.yaw_target)) * 16) / 50, 200, 824);
      pitch_pos = clamp(512 - ((int'($signed(cmd.pitch_target)) - 425) * 16) / 50, 200, 824);
      spd       = clamp(int'($signed(cmd.speed_request)), 0, 1023);
      spd_w     = spd[15:0];
      for (int p = 0; p < 2; p++) begin
         pos_w = (p == 0) ? yaw_pos[15:0] : pitch_pos[15:0];
         body  = '{(p == 0) ? spf_pkg::ID_YAW : spf_pkg::ID_PITCH, spf_pkg::LEN_BYTE,
                   spf_pkg::OP_WRITE, spf_pkg::ADDR_GOAL,
                   pos_w[15:8], pos_w[7:0], 8'h00, 8'h00, spd_w[15:8], spd_w[7:0]};
         sum   = 8'h00;
         expected_bytes.push_back('{spf_pkg::HDR_BYTE, 1'b0});
         expected_bytes.push_back('{spf_pkg::HDR_BYTE, 1'b0});
         foreach (body[i]) begin
            expected_bytes.push_back('{body[i], 1'b0});
            sum += body[i];
         end
         expected_bytes.push_back('{~sum, 1'(p == 1)});
      end
   endfunction

   function automatic spf_pkg::req_type random_command();
      spf_pkg::req_type c;
      int      mode;
      int      sgn;
      mode = $urandom_range(0, 9);
      sgn  = $urandom_range(0, 1) ? 1 : -1;
      if (mode < 4) begin
         c.yaw_target    = 16'(int'($urandom_range(0, 2560)) - 1280);
         c.pitch_target  = 16'($urandom_range(0, 850));
         c.speed_request = 16'($urandom_range(0, 1023));
      end else if (mode < 7) begin
         c.yaw_target    = 16'(sgn * int'($urandom_range(960, 1000)));
         c.pitch_target  = 16'(425 - sgn * int'($urandom_range(960, 1000)));
         c.speed_request = $urandom_range(0, 1) ? 16'(int'($urandom_range(0, 40)) - 20)
                                                : 16'($urandom_range(1000, 1050));
      end else begin
         c.yaw_target    = 16'($urandom);
         c.pitch_target  = 16'($urandom);
         c.speed_request = 16'($urandom);
      end
      return c;
   endfunction

   task automatic push_cmd(int yaw, int pitch, int speed);
      pending_cmds.push_back('{16'(yaw), 16'(pitch), 16'(speed)});
   endtask

   task automatic push_random(int n);
      repeat (n) pending_cmds.push_back(random_command());
   endtask

   // Hold until every command is taken and every byte has come, then let the queue settle.
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || start || expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_BUS_READY) bus_ready_copy = data[0];
   endtask

   // Command driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) frame_pose(req_cmd);
         if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            start   <= 1'b1;
            req_cmd <= pending_cmds.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Byte monitor and watchdog
   always @(posedge clock) begin : monitor
      spf_pkg::rsp_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected beat %02h last=%0b",
                                         rsp_beat.wire_byte, rsp_beat.last_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_beat.wire_byte !== want.wire_byte)
                  report_mismatch($sformatf("wire_byte %02h, want %02h",
                                            rsp_beat.wire_byte, want.wire_byte));
               if (rsp_beat.last_byte !== want.last_byte)
                  report_mismatch($sformatf("last_byte %0b, want %0b",
                                            rsp_beat.last_byte, want.last_byte));
            end
         end
         if ((start && !busy) || rsp_strobe || (csr_psel && csr_penable && csr_pwrite)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("[servo_pose_packet_framer_top] ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_reg(ADDR_BUS_READY, 32'h0000_0001);
      write_reg(ADDR_UNUSED, 32'h0000_0000);
      send_idle_pct = 26;
      push_cmd(0, 425, 0);
      push_cmd(1280, 0, 1023);
      push_cmd(-1280, 850, 512);
      push_cmd(-32768, -32768, -32768);
      push_cmd(32767, 32767, 32767);
      push_cmd(-1, -1, -1);
      push_cmd(975, -550, 1024);
      push_cmd(-975, 1400, 1);
      push_cmd(977, -552, 1022);
      push_cmd(979, -554, -2);
      push_cmd(-979, 1404, 2000);
      push_cmd(-3, 428, 100);
      push_cmd(3, 422, 100);
      push_cmd(-4, 429, 5);
      push_cmd(21845, -21846, 21845);
      push_cmd(-21846, 21845, -21846);
      push_cmd(0, 0, 0);
      push_cmd(1, 426, 1023);
      wait_drained();

      // bus not ready: commands are taken but frame nothing
      write_reg(ADDR_BUS_READY, 32'hFFFF_FFFE);
      send_idle_pct = 60;
      push_cmd(0, 425, 512);
      push_cmd(-32768, 32767, 1023);
      push_random(24);
      wait_drained();

      write_reg(ADDR_BUS_READY, 32'hFFFF_FFFF);
      send_idle_pct = 26;
      push_random(106);
      wait_drained();

      send_idle_pct = 60;
      push_random(60);
      wait_drained();
      push_random(60);
      wait_drained();

      send_idle_pct = 0;
      push_random(100);
      wait_drained();

      if (expected_bytes.size() != 0)
         report_mismatch($sformatf("%0d beats never came", expected_bytes.size()));
      if (errors == 0) begin
         $display("[servo_pose_packet_framer_top] OK");
      end else begin
         $display("[servo_pose_packet_framer_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/spf_pkg.sv
sv/spf_front.sv
sv/spf_queue.sv
sv/spf_back.sv
sv/servo_pose_packet_framer_top.sv
bench/tb_top.sv
